@@ rtl/dlsq_pkg.sv @@
// ----------------------------------------------------------------------------
// dlsq_pkg: shared types and constants of the delta list sleep queue
// operation and result codes, and the state codes of the list engine's state record
// ----------------------------------------------------------------------------
package dlsq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int ID_BITS_DEF   = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_INSERTED  = 3'd0,
        K_REJECTED  = 3'd1,
        K_EXPIRED   = 3'd2,
        K_CANCELLED = 3'd3,
        K_NOT_FOUND = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WALK,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FIND,
        S_TICK,
        S_EMIT
    } t_state;

endpackage

@@ rtl/delta_list_sleep_queue.sv @@
// ----------------------------------------------------------------------------
// delta_list_sleep_queue: sleep queue kept as an ordered delta list
// insert, tick and cancel of sleeping threads with wake reports
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid/o_ready carries op, thread id and sleep time;
//   output channel o_valid/i_ready carries kind, thread id and last flag.
//   a front queue of two words takes commands while the list engine works,
//   so up to two words can wait while a result sits in the output register.
//   insert walks the list one entry a cycle, then shifts the tail one entry
//   a cycle. cancel searches then shifts forward. a tick gives one result
//   per woken thread, the final one marked last.
//   unused op codes are dropped at the input with no result.
//   reset empties the list at once; entry storage is not cleared.
//   when the receiver stalls the result is held; the engine waits once it needs the output.
// ----------------------------------------------------------------------------
module delta_list_sleep_queue #(
    parameter int DEPTH     = dlsq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = dlsq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dlsq_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [ID_BITS-1:0]   i_thread_id,
    input  logic [TIME_BITS-1:0] i_sleep_time,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_thread_id_res,
    output logic                 o_last
);
    import dlsq_pkg::*;

    logic                 cvalid, cready;
    logic [1:0]           cop;
    logic [ID_BITS-1:0]   cid;
    logic [TIME_BITS-1:0] ctime;

    dlsq_front #(.TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_id(i_thread_id), .i_time(i_sleep_time),
        .o_cvalid(cvalid), .i_cready(cready),
        .o_cop(cop), .o_cid(cid), .o_ctime(ctime)
    );

    dlsq_back #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cvalid(cvalid), .o_cready(cready),
        .i_cop(cop), .i_cid(cid), .i_ctime(ctime),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_thread_id_res(o_thread_id_res), .o_last(o_last)
    );
endmodule

@@ rtl/dlsq_front.sv @@
// ----------------------------------------------------------------------------
// dlsq_front: command intake
// accepts words, drops unused codes and holds a two-entry command queue
// ----------------------------------------------------------------------------
module dlsq_front #(
    parameter int TIME_BITS = dlsq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dlsq_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic [TIME_BITS-1:0] i_time,
    output logic                 o_cvalid,
    input  logic                 i_cready,
    output logic [1:0]           o_cop,
    output logic [ID_BITS-1:0]   o_cid,
    output logic [TIME_BITS-1:0] o_ctime
);
    import dlsq_pkg::*;

    logic [1:0]           r_op   [2];
    logic [ID_BITS-1:0]   r_id   [2];
    logic [TIME_BITS-1:0] r_time [2];
    logic                 r_rd, r_wr;
    logic [1:0]           r_cnt;
    logic                 push, pop;

    assign o_ready  = (r_cnt != 2'd2);
    assign push     = i_valid && o_ready && (i_op != OP_NONE);
    assign o_cvalid = (r_cnt != 2'd0);
    assign pop      = o_cvalid && i_cready;
    assign o_cop    = r_op[r_rd];
    assign o_cid    = r_id[r_rd];
    assign o_ctime  = r_time[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr]   <= i_op;
            r_id[r_wr]   <= i_id;
            r_time[r_wr] <= i_time;
        end
    end
endmodule

@@ rtl/dlsq_back.sv @@
// ----------------------------------------------------------------------------
// dlsq_back: list engine
// walks and shifts the delta list one entry a cycle, emits result words
// ----------------------------------------------------------------------------
module dlsq_back #(
    parameter int DEPTH     = dlsq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = dlsq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dlsq_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cvalid,
    output logic                 o_cready,
    input  logic [1:0]           i_cop,
    input  logic [ID_BITS-1:0]   i_cid,
    input  logic [TIME_BITS-1:0] i_ctime,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_thread_id_res,
    output logic                 o_last
);
    import dlsq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // list held in flip-flops: each slot read at slot zero or through pointers around the current position
    logic [ID_BITS-1:0]   r_eid [DEPTH];
    logic [TIME_BITS-1:0] r_edl [DEPTH];
    logic [CW-1:0]        r_cnt, n_cnt;

    t_state               r_st, n_st;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_ip, n_ip;     // insert point
    logic [TIME_BITS:0]   r_rem, n_rem;   // time still left during insert walk
    logic [ID_BITS-1:0]   r_id, n_id;
    logic                 r_tick, n_tick; // removal belongs to a tick

    // output register
    logic                 r_ov, n_ov;
    logic [2:0]           r_ok, n_ok;
    logic [7:0]           r_oid, n_oid;
    logic                 r_ol, n_ol;

    logic [AW-1:0]        pa, pm;
    logic [TIME_BITS-1:0] dp, dh;
    logic                 oreg_free;

    // list write controls
    logic                 w_up, w_dn, w_ins, w_dec, w_add;

    assign pa        = r_pos[AW-1:0];
    assign pm        = AW'(r_pos - CW'(1));
    assign dp        = r_edl[pa];
    assign dh        = r_edl[0];
    assign oreg_free = !r_ov || i_ready;
    assign o_valid   = r_ov;
    assign o_kind    = r_ok;
    assign o_thread_id_res = r_oid;
    assign o_last    = r_ol;

    always_comb begin
        n_st = r_st; n_pos = r_pos; n_ip = r_ip; n_rem = r_rem; n_id = r_id;
        n_tick = r_tick; n_cnt = r_cnt;
        n_ov = r_ov && !i_ready; n_ok = r_ok; n_oid = r_oid; n_ol = r_ol;
        o_cready = 1'b0;
        w_up = 1'b0; w_dn = 1'b0; w_ins = 1'b0; w_dec = 1'b0; w_add = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_cvalid && oreg_free) begin
                    o_cready = 1'b1;
                    n_id = i_cid;
                    unique case (t_op'(i_cop))
                        OP_INSERT: begin
                            if (i_ctime == '0 || r_cnt == CW'(DEPTH)) begin
                                n_ov = 1'b1; n_ok = K_REJECTED;
                                n_oid = 8'(i_cid); n_ol = 1'b1;
                            end else begin
                                n_pos = '0;
                                n_rem = {1'b0, i_ctime};
                                n_st = S_INS_WALK;
                            end
                        end
                        OP_TICK: begin
                            if (r_cnt != '0) n_st = S_TICK;
                        end
                        OP_CANCEL: begin
                            n_pos = '0;
                            n_st = S_FIND;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_WALK: begin
                // advance while prefix sum plus delta stays below the time
                if (r_pos < r_cnt && {1'b0, dp} < r_rem) begin
                    n_rem = r_rem - {1'b0, dp};
                    n_pos = r_pos + CW'(1);
                end else begin
                    n_st = S_SHIFT_UP;
                    n_ip = r_pos;
                    n_pos = r_cnt;
                    n_tick = 1'b0;
                end
            end
            S_SHIFT_UP: begin
                if (r_pos > r_ip) begin
                    w_up = 1'b1;
                    n_pos = r_pos - CW'(1);
                end else if (oreg_free) begin
                    w_ins = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    n_ov = 1'b1; n_ok = K_INSERTED; n_oid = 8'(r_id); n_ol = 1'b1;
                    n_st = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_pos >= r_cnt) begin
                    if (oreg_free) begin
                        n_ov = 1'b1; n_ok = K_NOT_FOUND; n_oid = 8'(r_id); n_ol = 1'b1;
                        n_st = S_IDLE;
                    end
                end else if (r_eid[pa] == r_id) begin
                    w_add = 1'b1;
                    n_tick = 1'b0;
                    n_st = S_SHIFT_DN;
                end else begin
                    n_pos = r_pos + CW'(1);
                end
            end
            S_SHIFT_DN: begin
                if (r_pos + CW'(1) < r_cnt) begin
                    w_dn = 1'b1;
                    n_pos = r_pos + CW'(1);
                end else if (oreg_free) begin
                    n_cnt = r_cnt - CW'(1);
                    if (r_tick) begin
                        // the shift has moved the next entry to the head
                        n_ov = 1'b1; n_ok = K_EXPIRED; n_oid = 8'(r_id);
                        n_ol = (n_cnt == '0) || (r_edl[0] != '0);
                        n_st = n_ol ? S_IDLE : S_EMIT;
                    end else begin
                        n_ov = 1'b1; n_ok = K_CANCELLED; n_oid = 8'(r_id); n_ol = 1'b1;
                        n_st = S_IDLE;
                    end
                end
            end
            S_TICK: begin
                if (dh != '0) w_dec = 1'b1;
                if (dh <= TIME_BITS'(1)) n_st = S_EMIT;
                else n_st = S_IDLE;
            end
            S_EMIT: begin
                // keep the head id, then remove the head
                n_id = r_eid[0];
                n_pos = '0;
                n_tick = 1'b1;
                n_st = S_SHIFT_DN;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_tick <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ov <= n_ov;
            r_tick <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos; r_rem <= n_rem; r_id <= n_id; r_ip <= n_ip;
        r_ok <= n_ok; r_oid <= n_oid; r_ol <= n_ol;
        if (w_up) begin
            r_eid[pa] <= r_eid[pm];
            r_edl[pa] <= r_edl[pm];
        end
        if (w_ins) begin
            r_eid[pa] <= r_id;
            r_edl[pa] <= r_rem[TIME_BITS-1:0];
            if (r_pos + CW'(1) <= r_cnt)
                r_edl[AW'(r_pos + CW'(1))] <=
                    r_edl[AW'(r_pos + CW'(1))] - r_rem[TIME_BITS-1:0];
        end
        if (w_add && r_pos + CW'(1) < r_cnt)
            r_edl[AW'(r_pos + CW'(1))] <= r_edl[AW'(r_pos + CW'(1))] + dp;
        if (w_dn) begin
            r_eid[pa] <= r_eid[AW'(r_pos + CW'(1))];
            r_edl[pa] <= r_edl[AW'(r_pos + CW'(1))];
        end
        if (w_dec) r_edl[0] <= dh - TIME_BITS'(1);
    end
endmodule
